FILE: hw/rtl/sfl_pkg.sv
// Shared types and constants for the sorted table floor lookup.
// Field widths, status codes and parameter defaults; no dependencies.
`default_nettype none

package sfl_pkg;

    localparam int KEY_W    = 23;
    localparam int RATE_W   = 32;
    localparam int AMT_W    = 21;
    localparam int VALUE_W  = 42;
    localparam int STATUS_W = 3;
    // amount and rate are fixed point with this many fraction bits
    localparam int FRAC_W   = 8;

    localparam int DEF_TABLE_DEPTH  = 4096;
    localparam int DEF_AMOUNT_LIMIT = 1000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_NEG    = 3'd1,
        ST_OVER   = 3'd2,
        ST_BEFORE = 3'd3,
        ST_EMPTY  = 3'd4,
        ST_FULL   = 3'd5
    } status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sfl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sfl_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_table_floor_lookup.sv
// Top level of the sorted table floor lookup: sequencer, search, insert shift, multiply.
// Depends on sfl_pkg and sfl_ram.
//
// Keeps up to TABLE_DEPTH (key, rate) entries sorted by key in one RAM. A query
// binary-searches the table, one probe per clock through the RAM read port, for
// the greatest key not above its key, then multiplies amount by the rate found.
// Amount and empty-table errors skip the search. An insert takes the same search,
// then moves every entry above the insert point up by one, one entry per cycle.
// An overwrite of an existing key skips the move. Only one transaction is in
// work at a time; the finished result sits in an output register, so the next
// transaction may start while it waits to be taken.
`default_nettype none

module sorted_table_floor_lookup
    import sfl_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int AMOUNT_LIMIT = DEF_AMOUNT_LIMIT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     func,
    input  wire logic        [KEY_W-1:0]  key,
    input  wire logic        [RATE_W-1:0] rate_in,
    input  wire logic signed [AMT_W-1:0]  amount,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [STATUS_W-1:0]           status,
    output logic [RATE_W-1:0]             rate_out,
    output logic [VALUE_W-1:0]            value
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = KEY_W + RATE_W;
    localparam int MAG_W   = AMT_W - 1;
    localparam int PROD_W  = MAG_W + RATE_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [MAG_W-1:0] AMT_MAX   = MAG_W'(AMOUNT_LIMIT * (1 << FRAC_W));

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_QRES,
        S_MUL,
        S_INS,
        S_SHIFT,
        S_PLACE,
        S_FINISH
    } state_t;

    state_t              state_reg,      state_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic [CNT_W-1:0]    lo_reg,         lo_next;
    logic [CNT_W-1:0]    hi_reg,         hi_next;
    logic [CNT_W-1:0]    mid_reg,        mid_next;
    logic [CNT_W-1:0]    ptr_reg,        ptr_next;
    logic                match_reg,      match_next;
    logic                query_reg,      query_next;
    logic [KEY_W-1:0]    key_reg,        key_next;
    logic [RATE_W-1:0]   rate_reg,       rate_next;
    logic [MAG_W-1:0]    amt_reg,        amt_next;
    logic [RATE_W-1:0]   found_reg,      found_next;
    logic [PROD_W-1:0]   prod_reg,       prod_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg,  out_valid_next;
    status_t             status_reg,     status_next;
    logic [RATE_W-1:0]   rate_out_reg,   rate_out_next;
    logic [VALUE_W-1:0]  value_reg,      value_next;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic [KEY_W-1:0]    probe_key;
    logic [RATE_W-1:0]   probe_rate;
    logic                go_right;
    logic                in_accept;

    sfl_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign probe_key  = ram_rd_data[ENTRY_W-1:RATE_W];
    assign probe_rate = ram_rd_data[RATE_W-1:0];
    // query looks for count of keys <= key, insert for count of keys < key
    assign go_right   = query_reg ? (probe_key <= key_reg) : (probe_key < key_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        ptr_next        = ptr_reg;
        match_next      = match_reg;
        query_next      = query_reg;
        key_next        = key_reg;
        rate_next       = rate_reg;
        amt_next        = amt_reg;
        found_next      = found_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        rate_out_next   = rate_out_reg;
        value_next      = value_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = lo_reg[ADDR_W-1:0];
        ram_wr_data = {key_reg, rate_reg};
        ram_rd_addr = mid_reg[ADDR_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    query_next      = (func == FUNC_QUERY);
                    key_next        = key;
                    rate_next       = rate_in;
                    amt_next        = amount[MAG_W-1:0];
                    found_next      = '0;
                    prod_next       = '0;
                    res_status_next = ST_OK;
                    match_next      = 1'b0;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    mid_next        = count_reg >> 1;
                    ram_rd_addr     = mid_next[ADDR_W-1:0];
                    if (func == FUNC_QUERY)
                    begin
                        priority if (amount[AMT_W-1])
                        begin
                            res_status_next = ST_NEG;
                            state_next      = S_FINISH;
                        end
                        else if (amount[MAG_W-1:0] > AMT_MAX)
                        begin
                            res_status_next = ST_OVER;
                            state_next      = S_FINISH;
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // read data is the entry at mid_reg, requested last cycle
                if (go_right)
                begin
                    lo_next    = mid_reg + 1'b1;
                    found_next = probe_rate;
                end
                else
                begin
                    hi_next    = mid_reg;
                    match_next = (probe_key == key_reg);
                end
                mid_next    = lo_next + ((hi_next - lo_next) >> 1);
                ram_rd_addr = mid_next[ADDR_W-1:0];
                if (lo_next == hi_next)
                begin
                    state_next = query_reg ? S_QRES : S_INS;
                end
            end

            S_QRES:
            begin
                if (lo_reg == '0)
                begin
                    res_status_next = ST_BEFORE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                prod_next  = PROD_W'(amt_reg) * PROD_W'(found_reg);
                state_next = S_FINISH;
            end

            S_INS:
            begin
                // match_reg holds the compare of the last probe that lowered hi,
                // which is the entry at the insert point
                priority if (match_reg)
                begin
                    ram_wr_en  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (count_reg == DEPTH_CNT)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_FINISH;
                end
                else if (lo_reg == count_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ptr_next    = count_reg - 1'b1;
                    ram_rd_addr = ptr_next[ADDR_W-1:0];
                    state_next  = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // move entry ptr up by one while reading ptr-1
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(ptr_reg + 1'b1);
                ram_wr_data = ram_rd_data;
                if (ptr_reg == lo_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ptr_next    = ptr_reg - 1'b1;
                    ram_rd_addr = ptr_next[ADDR_W-1:0];
                end
            end

            S_PLACE:
            begin
                ram_wr_en  = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    if (query_reg && res_status_reg == ST_OK)
                    begin
                        rate_out_next = found_reg;
                        value_next    = prod_reg[FRAC_W +: VALUE_W];
                    end
                    else
                    begin
                        rate_out_next = '0;
                        value_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        ptr_reg        <= ptr_next;
        match_reg      <= match_next;
        query_reg      <= query_next;
        key_reg        <= key_next;
        rate_reg       <= rate_next;
        amt_reg        <= amt_next;
        found_reg      <= found_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        status_reg     <= status_next;
        rate_out_reg   <= rate_out_next;
        value_reg      <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign rate_out  = rate_out_reg;
    assign value     = value_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above table depth");

    a_search_open : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> lo_reg < hi_reg)
        else $error("search running on an empty interval");

    a_write_state : assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == S_INS || state_reg == S_SHIFT || state_reg == S_PLACE))
        else $error("table write outside insert sequence");

    a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> rate_out == '0 && value == '0)
        else $error("error result carries nonzero payload");

endmodule

`default_nettype wire

FILE: tb/sv/sorted_table_floor_lookup_test.sv
// Self-checking testbench for sorted_table_floor_lookup: directed and random traffic.
// Depends on sfl_pkg and the sorted_table_floor_lookup RTL; a scoreboard class predicts each result.

module sorted_table_floor_lookup_test;
    import sfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
    localparam int AMOUNT_LIMIT = DEF_AMOUNT_LIMIT;
    localparam int unsigned AMT_CEIL = AMOUNT_LIMIT << FRAC_W;
    localparam int unsigned RAND_KEY_MAX = 32'h7FDFFF;
    localparam int unsigned CYCLE_LIMIT  = 3000000;
    localparam int PHASE_ITEMS = 460;

    typedef struct {
        status_t             status;
        logic [RATE_W-1:0]   rate;
        logic [VALUE_W-1:0]  value;
    } lookup_result_t;

    class lookup_scoreboard;
        bit [KEY_W-1:0]  keys[TABLE_DEPTH];
        bit [RATE_W-1:0] rates[TABLE_DEPTH];
        int unsigned     count;
        lookup_result_t  pending[$];
        int              mismatches;

        // number of stored keys below k, or at or below k when inclusive
        function int unsigned keys_below(bit [KEY_W-1:0] k, bit inclusive);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = count;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (keys[mid] < k || (inclusive && keys[mid] == k))
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function bit [KEY_W-1:0] stored_key();
            if (count == 0)
                return '0;
            return keys[$urandom_range(count - 1, 0)];
        endfunction

        function void note_transaction(func_t f, logic [KEY_W-1:0] k, logic [RATE_W-1:0] r,
                                       logic [AMT_W-1:0] a);
            lookup_result_t res;
            int unsigned pos;
            res.status = ST_OK;
            res.rate = '0;
            res.value = '0;
            if (f == FUNC_INSERT) begin
                pos = keys_below(k, 1'b0);
                if (pos < count && keys[pos] == k) begin
                    rates[pos] = r;
                end
                else if (count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end
                else begin
                    for (int i = count; i > pos; i--) begin
                        keys[i] = keys[i-1];
                        rates[i] = rates[i-1];
                    end
                    keys[pos] = k;
                    rates[pos] = r;
                    count++;
                end
            end
            else if (a[AMT_W-1]) begin
                res.status = ST_NEG;
            end
            else if (a > AMT_CEIL) begin
                res.status = ST_OVER;
            end
            else if (count == 0) begin
                res.status = ST_EMPTY;
            end
            else begin
                pos = keys_below(k, 1'b1);
                if (pos == 0) begin
                    res.status = ST_BEFORE;
                end
                else begin
                    res.rate = rates[pos-1];
                    res.value = VALUE_W'((64'(a) * 64'(res.rate)) >> FRAC_W);
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [RATE_W-1:0] r,
                                   logic [VALUE_W-1:0] v);
            lookup_result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: status %0d rate %h value %h",
                         $time, st, r, v);
                return;
            end
            want = pending.pop_front();
            if (st !== want.status) begin
                mismatches++;
                $display("%0t: status expected %0d, got %0d", $time, want.status, st);
            end
            if (r !== want.rate) begin
                mismatches++;
                $display("%0t: rate_out expected %h, got %h", $time, want.rate, r);
            end
            if (v !== want.value) begin
                mismatches++;
                $display("%0t: value expected %h, got %h", $time, want.value, v);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     func;
    logic        [KEY_W-1:0]  key;
    logic        [RATE_W-1:0] rate_in;
    logic signed [AMT_W-1:0]  amount;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic [RATE_W-1:0]        rate_out;
    logic [VALUE_W-1:0]       value;

    int send_idle_pct;
    int recv_stall_pct;
    int unsigned cycle_count = 0;
    lookup_scoreboard board = new;

    sorted_table_floor_lookup #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .AMOUNT_LIMIT (AMOUNT_LIMIT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .key       (key),
        .rate_in   (rate_in),
        .amount    (amount),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .rate_out  (rate_out),
        .value     (value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_transaction(func_t'(func), key, rate_in, amount);
        if (rst_n && out_valid && !out_stall)
            board.check_result(status, rate_out, value);
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // entered at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input func_t f, input logic [KEY_W-1:0] k,
                             input logic [RATE_W-1:0] r, input logic [AMT_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        key      <= k;
        rate_in  <= r;
        amount   <= a;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending.size() != 0);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return KEY_W'($urandom_range(255, 0));
            1: return KEY_W'($urandom_range(2030, 1990) * 512 + $urandom_range(12, 1) * 32
                             + $urandom_range(31, 1));
            default: return KEY_W'($urandom_range(RAND_KEY_MAX, 0));
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return RATE_W'($urandom_range(255, 1));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(19))
            0: return AMT_W'(-int'($urandom_range(32'h100000, 1)));
            1: return AMT_W'($urandom_range(32'hFFFFF, AMT_CEIL + 1));
            2: return AMT_W'(AMT_CEIL);
            3: return '0;
            default: return AMT_W'($urandom_range(AMT_CEIL, 0));
        endcase
    endfunction

    task automatic send_random();
        func_t            f;
        logic [KEY_W-1:0] k;
        f = ($urandom_range(99) < 30) ? FUNC_INSERT : FUNC_QUERY;
        if (board.count == 0)
            k = pick_key();
        else if (f == FUNC_INSERT)
            k = ($urandom_range(4) == 0) ? board.stored_key() : pick_key();
        else begin
            case ($urandom_range(9))
                0, 1, 2, 3: k = board.stored_key();
                4, 5: k = board.stored_key() + KEY_W'($urandom_range(40, 1));
                6: k = (board.keys[0] == 0) ? '0 : KEY_W'($urandom_range(board.keys[0] - 1, 0));
                default: k = pick_key();
            endcase
        end
        send_item(f, k, pick_rate(), pick_amount());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_INSERT;
        key = '0;
        rate_in = '0;
        amount = '0;
        send_idle_pct = 32;
        recv_stall_pct = 78;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table and amount checks
        send_item(FUNC_QUERY, '0, '0, '0);
        send_item(FUNC_QUERY, '0, '0, '1);
        send_item(FUNC_QUERY, '1, '1, AMT_W'(32'h100000));
        send_item(FUNC_QUERY, '1, '0, AMT_W'(32'hFFFFF));
        send_item(FUNC_QUERY, 23'd500, '0, AMT_W'(AMT_CEIL + 1));
        send_item(FUNC_QUERY, '1, '0, AMT_W'(AMT_CEIL));
        // small table, middle insert, overwrite, front insert
        send_item(FUNC_INSERT, 23'd1000, 32'h100, '0);
        send_item(FUNC_INSERT, 23'd3000, '1, '1);
        send_item(FUNC_INSERT, 23'd2000, 32'h80, '0);
        send_item(FUNC_QUERY, 23'd999, '0, 21'd256);
        send_item(FUNC_QUERY, '0, '0, 21'd256);
        send_item(FUNC_QUERY, 23'd1000, '0, 21'd256);
        send_item(FUNC_QUERY, 23'd2999, '0, AMT_W'(AMT_CEIL));
        send_item(FUNC_QUERY, 23'd3000, '0, AMT_W'(AMT_CEIL));
        send_item(FUNC_QUERY, '1, '0, 21'd255);
        send_item(FUNC_INSERT, 23'd2000, 32'h12345678, '0);
        send_item(FUNC_QUERY, 23'd2500, '0, 21'd1);
        send_item(FUNC_INSERT, '0, '0, '0);
        send_item(FUNC_QUERY, '0, '0, 21'd100);
        send_item(FUNC_QUERY, '1, '0, '1);
        send_item(FUNC_QUERY, 23'd500, '0, AMT_W'(AMT_CEIL + 1));
        send_item(FUNC_QUERY, 23'd1, '0, '0);

        repeat (PHASE_ITEMS) send_random();
        wait_drained();
        send_idle_pct = 78;
        recv_stall_pct = 32;
        repeat (PHASE_ITEMS) send_random();
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (PHASE_ITEMS) send_random();
        wait_drained();

        repeat (40) @(negedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sfl_pkg.sv
hw/rtl/sfl_ram.sv
hw/rtl/sorted_table_floor_lookup.sv
tb/sv/sorted_table_floor_lookup_test.sv
